@@ hdl/grc_pkg.sv @@
// Shared types for the Givens rotation coefficient core.
// No dependencies.
package grc_pkg;

   typedef struct packed {
      logic neg_cos;
      logic neg_sin;
      logic b_zero;
   } grc_flags_type;

endpackage

@@ hdl/grc_front.sv @@
// Front end: magnitudes, squares, sum and the initial residuals of both lanes.
// Depends on grc_pkg.
module grc_front #(
   parameter int W  = 32,
   parameter int F  = 30,
   parameter int RW = 2 * W + 2 * F + 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [W-1:0]               in_a,
   input  logic [W-1:0]               in_b,
   output logic                       out_valid,
   input  logic                       out_ready,
   output grc_pkg::grc_flags_type     out_flags,
   output logic signed [RW-1:0]       out_sum,
   output logic signed [RW-1:0]       out_r_cos,
   output logic signed [RW-1:0]       out_r_sin,
   output logic signed [RW-1:0]       out_p
);
   import grc_pkg::*;

   logic           v1_ff, v2_ff, v3_ff;
   logic           rdy1, rdy2, rdy3;
   logic [W-1:0]   ma_ff, mb_ff, ma_in, mb_in;
   logic           na_ff, nb_ff;
   logic [2*W-1:0] sa_ff, sb_ff;
   grc_flags_type  fl2_ff, fl2_in, fl3_ff;
   logic signed [RW-1:0] sum_ff, rc_ff, rs_ff, p_ff;
   logic signed [RW-1:0] sum_in, ta, tb;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign ma_in = in_a[W-1] ? (~in_a + W'(1)) : in_a;
   assign mb_in = in_b[W-1] ? (~in_b + W'(1)) : in_b;

   always_comb begin
      fl2_in.b_zero  = (mb_ff == '0);
      fl2_in.neg_cos = (na_ff != nb_ff) && (mb_ff > ma_ff);
      fl2_in.neg_sin = (na_ff != nb_ff) && !(mb_ff > ma_ff);
   end

   assign sum_in = RW'(sa_ff) + RW'(sb_ff);
   assign ta     = RW'(sa_ff) <<< (2 * F + 2);
   assign tb     = RW'(sb_ff) <<< (2 * F + 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         ma_ff <= ma_in;
         mb_ff <= mb_in;
         na_ff <= in_a[W-1];
         nb_ff <= in_b[W-1];
      end
      if (rdy2) begin
         sa_ff  <= (2*W)'(ma_ff) * (2*W)'(ma_ff);
         sb_ff  <= (2*W)'(mb_ff) * (2*W)'(mb_ff);
         fl2_ff <= fl2_in;
      end
      if (rdy3) begin
         sum_ff <= sum_in;
         rc_ff  <= ta - sum_in;
         rs_ff  <= tb - sum_in;
         p_ff   <= -sum_in;
         fl3_ff <= fl2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_flags = fl3_ff;
   assign out_sum   = sum_ff;
   assign out_r_cos = rc_ff;
   assign out_r_sin = rs_ff;
   assign out_p     = p_ff;
endmodule

@@ hdl/grc_cell.sv @@
// One quotient bit of both lanes: trial subtract of the odd-square residual.
// Depends on grc_pkg.
module grc_cell #(
   parameter int W    = 32,
   parameter int F    = 30,
   parameter int RW   = 2 * W + 2 * F + 6,
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  grc_pkg::grc_flags_type in_flags,
   input  logic signed [RW-1:0]   in_sum,
   input  logic signed [RW-1:0]   in_r_cos,
   input  logic signed [RW-1:0]   in_p_cos,
   input  logic [F:0]             in_q_cos,
   input  logic signed [RW-1:0]   in_r_sin,
   input  logic signed [RW-1:0]   in_p_sin,
   input  logic [F:0]             in_q_sin,
   output logic                   out_valid,
   input  logic                   out_ready,
   output grc_pkg::grc_flags_type out_flags,
   output logic signed [RW-1:0]   out_sum,
   output logic signed [RW-1:0]   out_r_cos,
   output logic signed [RW-1:0]   out_p_cos,
   output logic [F:0]             out_q_cos,
   output logic signed [RW-1:0]   out_r_sin,
   output logic signed [RW-1:0]   out_p_sin,
   output logic [F:0]             out_q_sin
);
   import grc_pkg::*;

   logic                 v_ff;
   grc_flags_type        fl_ff;
   logic signed [RW-1:0] sum_ff, rc_ff, pc_ff, rs_ff, ps_ff;
   logic [F:0]           qc_ff, qs_ff;
   logic signed [RW-1:0] sq, tc, ts, inc;

   assign in_ready = !v_ff || out_ready;
   assign sq  = in_sum <<< (2 * STEP + 2);
   assign inc = in_sum <<< (STEP + 1);
   assign tc  = in_r_cos - (in_p_cos <<< (STEP + 2)) - sq;
   assign ts  = in_r_sin - (in_p_sin <<< (STEP + 2)) - sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         fl_ff  <= in_flags;
         sum_ff <= in_sum;
         rc_ff  <= tc[RW-1] ? in_r_cos : tc;
         pc_ff  <= tc[RW-1] ? in_p_cos : in_p_cos + inc;
         qc_ff  <= in_q_cos | ((F+1)'(!tc[RW-1]) << STEP);
         rs_ff  <= ts[RW-1] ? in_r_sin : ts;
         ps_ff  <= ts[RW-1] ? in_p_sin : in_p_sin + inc;
         qs_ff  <= in_q_sin | ((F+1)'(!ts[RW-1]) << STEP);
      end
   end

   assign out_valid = v_ff;
   assign out_flags = fl_ff;
   assign out_sum   = sum_ff;
   assign out_r_cos = rc_ff;
   assign out_p_cos = pc_ff;
   assign out_q_cos = qc_ff;
   assign out_r_sin = rs_ff;
   assign out_p_sin = ps_ff;
   assign out_q_sin = qs_ff;
endmodule

@@ hdl/givens_rotation_coefficients_core.sv @@
// Top level of the Givens rotation coefficient core.
// Depends on grc_pkg, grc_front and grc_cell.
//
// Usage:
//  req channel: one item is a pair (a_value, b_value) of signed integers.
//  rsp channel: one item is (cosine, sine) in signed Q2.FRACTION_BITS, giving
//  the rotation that zeroes b. b of zero gives cosine 1.0, sine 0.
//  Each magnitude is |x|/sqrt(a^2+b^2) rounded to nearest, halves away from
//  zero; the sign of a*b lands on the lane of the smaller magnitude (sine on a tie).
//  Pipeline: FRACTION_BITS+5 register stages: three front stages (magnitudes,
//  squares, sum), one cell per quotient bit, one output stage.
//  Throughput: one item per cycle while rsp is not stalled; every cell is a
//  register stage. Each stage holds its item while the next stage is full, so
//  empty stages still take new items while rsp is stalled; req_tready drops
//  only when the whole chain is full. Reset empties the chain; no results are
//  lost or duplicated across stalls.
module givens_rotation_coefficients_core #(
   parameter int INPUT_WIDTH   = 32,
   parameter int FRACTION_BITS = 30
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_value, b_value
   input  logic [((2*INPUT_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // cosine, sine
   output logic [((2*FRACTION_BITS+4+7)/8)*8-1:0] rsp_tdata
);
   import grc_pkg::*;

   localparam int W    = INPUT_WIDTH;
   localparam int F    = FRACTION_BITS;
   localparam int RW   = 2 * W + 2 * F + 6;
   localparam int OW   = F + 2;
   localparam int ODW  = ((2 * OW + 7) / 8) * 8;
   localparam logic [OW-1:0] ONE = OW'(1) << F;

   logic                 v [0:F+1];
   logic                 rdy [0:F+1];
   grc_flags_type        fl [0:F+1];
   logic signed [RW-1:0] sm [0:F+1];
   logic signed [RW-1:0] rc [0:F+1];
   logic signed [RW-1:0] pc [0:F+1];
   logic signed [RW-1:0] rs [0:F+1];
   logic signed [RW-1:0] ps [0:F+1];
   logic [F:0]           qc [0:F+1];
   logic [F:0]           qs [0:F+1];
   logic signed [RW-1:0] p0;

   logic                 ov_ff;
   logic [OW-1:0]        cos_ff, sin_ff, cos_in, sin_in;

   grc_front #(.W(W), .F(F), .RW(RW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_a      (req_tdata[W-1:0]),
      .in_b      (req_tdata[2*W-1:W]),
      .out_valid (v[0]),
      .out_ready (rdy[0]),
      .out_flags (fl[0]),
      .out_sum   (sm[0]),
      .out_r_cos (rc[0]),
      .out_r_sin (rs[0]),
      .out_p     (p0)
   );

   assign pc[0] = p0;
   assign ps[0] = p0;
   assign qc[0] = '0;
   assign qs[0] = '0;

   for (genvar i = 0; i <= F; i++) begin : g_cell
      grc_cell #(.W(W), .F(F), .RW(RW), .STEP(F - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v[i]),
         .in_ready  (rdy[i]),
         .in_flags  (fl[i]),
         .in_sum    (sm[i]),
         .in_r_cos  (rc[i]),
         .in_p_cos  (pc[i]),
         .in_q_cos  (qc[i]),
         .in_r_sin  (rs[i]),
         .in_p_sin  (ps[i]),
         .in_q_sin  (qs[i]),
         .out_valid (v[i+1]),
         .out_ready (rdy[i+1]),
         .out_flags (fl[i+1]),
         .out_sum   (sm[i+1]),
         .out_r_cos (rc[i+1]),
         .out_p_cos (pc[i+1]),
         .out_q_cos (qc[i+1]),
         .out_r_sin (rs[i+1]),
         .out_p_sin (ps[i+1]),
         .out_q_sin (qs[i+1])
      );
   end

   assign rdy[F+1] = !ov_ff || rsp_tready;

   always_comb begin
      if (fl[F+1].b_zero) begin
         cos_in = ONE;
         sin_in = '0;
      end else begin
         cos_in = fl[F+1].neg_cos ? -OW'(qc[F+1]) : OW'(qc[F+1]);
         sin_in = fl[F+1].neg_sin ? -OW'(qs[F+1]) : OW'(qs[F+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (rdy[F+1]) begin
         ov_ff <= v[F+1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[F+1]) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = ODW'({sin_ff, cos_ff});

   a_cos_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(cos_ff) <= $signed(ONE) && $signed(cos_ff) >= -$signed(ONE)))
      else $error("cosine out of range");
   a_sin_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(sin_ff) <= $signed(ONE) && $signed(sin_ff) >= -$signed(ONE)))
      else $error("sine out of range");
   a_one_neg : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(cos_ff[OW-1] && sin_ff[OW-1]))
      else $error("both coefficients negative");
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
endmodule
